@@ rtl/core/hkc_pkg.sv @@
// ----------------------------------------------------------------------------
// hkc_pkg: shared types and constants of the hex keypad calculator core
// Widths, key codes, operator codes, sequencer states and the control word
// of the shared multiply/divide unit.
// ----------------------------------------------------------------------------
package hkc_pkg;

   // Widths fixed by the interface
   localparam int DataWidth = 32;
   localparam int KeyWidth  = 8;
   localparam int OpWidth   = 2;
   localparam int StepWidth = $clog2(DataWidth);

   // Request op codes
   localparam logic [OpWidth-1:0] ReqOpTyped  = 2'd0;
   localparam logic [OpWidth-1:0] ReqOpButton = 2'd1;
   localparam logic [OpWidth-1:0] ReqOpLeft   = 2'd2;
   localparam logic [OpWidth-1:0] ReqOpNone   = 2'd3;

   // Key codes
   localparam logic [KeyWidth-1:0] KeyBackspace = 8'd8;
   localparam logic [KeyWidth-1:0] KeyEnter     = 8'd13;
   localparam logic [KeyWidth-1:0] KeyEscape    = 8'd27;
   localparam logic [KeyWidth-1:0] KeyCaseShift = 8'd32;

   // Operator codes (ASCII)
   localparam logic [KeyWidth-1:0] OpEquals = 8'h3d;
   localparam logic [KeyWidth-1:0] OpAdd    = 8'h2b;
   localparam logic [KeyWidth-1:0] OpSub    = 8'h2d;
   localparam logic [KeyWidth-1:0] OpMul    = 8'h2a;
   localparam logic [KeyWidth-1:0] OpAnd    = 8'h26;
   localparam logic [KeyWidth-1:0] OpOr     = 8'h7c;
   localparam logic [KeyWidth-1:0] OpXor    = 8'h5e;
   localparam logic [KeyWidth-1:0] OpShl    = 8'h3c;
   localparam logic [KeyWidth-1:0] OpShr    = 8'h3e;
   localparam logic [KeyWidth-1:0] OpDiv    = 8'h2f;
   localparam logic [KeyWidth-1:0] OpMod    = 8'h25;

   localparam logic [DataWidth-1:0] AllOnes = {DataWidth{1'b1}};

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_WAIT,
      ST_WRITE
   } state_type;

   // Shared unit commands
   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } alu_cmd_type;

   typedef struct packed {
      logic        start;
      alu_cmd_type cmd;
   } alu_ctrl_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   // Decode a hex digit key, upper or lower case
   function automatic digit_type digit_decode(input logic [KeyWidth-1:0] key);
      digit_type d;
      d.valid = 1'b0;
      d.value = 4'd0;
      if (key >= 8'h30 && key <= 8'h39) begin
         d.valid = 1'b1;
         d.value = 4'(key - 8'h30);
      end else if (key >= 8'h41 && key <= 8'h46) begin
         d.valid = 1'b1;
         d.value = 4'(key - 8'h37);
      end else if (key >= 8'h61 && key <= 8'h66) begin
         d.valid = 1'b1;
         d.value = 4'(key - 8'h57);
      end
      return d;
   endfunction

endpackage

@@ rtl/core/hkc_alu.sv @@
// ----------------------------------------------------------------------------
// hkc_alu: shared iterative multiply/divide unit
// One adder, stepped once per cycle: shift-and-add multiply (low word kept)
// or restoring divide giving quotient and remainder.
// ----------------------------------------------------------------------------
module hkc_alu import hkc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  alu_ctrl_type         ctrl,
   input  logic [DataWidth-1:0] opnd_a,
   input  logic [DataWidth-1:0] opnd_b,
   output logic                 done,
   output logic [DataWidth-1:0] res_hi,
   output logic [DataWidth-1:0] res_lo
);

   alu_cmd_type          cmd_ff;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [StepWidth-1:0] count_ff, count_in;
   logic [DataWidth-1:0] hi_ff, hi_in;
   logic [DataWidth-1:0] lo_ff, lo_in;
   logic [DataWidth-1:0] oper_ff, oper_in;

   logic [DataWidth:0]   add_a, add_b;
   logic [DataWidth+1:0] sum;
   logic                 carry, ge;

   // Shared adder: add for multiply, trial subtract for divide
   always_comb begin
      carry = (cmd_ff == ALU_DIV);
      if (cmd_ff == ALU_MUL) begin
         add_a = {1'b0, hi_ff};
         add_b = {1'b0, oper_ff};
      end else begin
         add_a = {hi_ff, lo_ff[DataWidth-1]};
         add_b = ~{1'b0, oper_ff};
      end
      sum = {1'b0, add_a} + {1'b0, add_b} + {{(DataWidth+1){1'b0}}, carry};
      ge  = sum[DataWidth+1];
   end

   // Step the working registers
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      oper_in  = oper_ff;
      if (ctrl.start) begin
         busy_in  = 1'b1;
         count_in = StepWidth'(DataWidth - 1);
         hi_in    = '0;
         if (ctrl.cmd == ALU_MUL) begin
            lo_in   = opnd_b;
            oper_in = opnd_a;
         end else begin
            lo_in   = opnd_a;
            oper_in = opnd_b;
         end
      end else if (busy_ff) begin
         count_in = count_ff - StepWidth'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (cmd_ff == ALU_MUL) begin
            hi_in   = lo_ff[0] ? sum[DataWidth-1:0] : hi_ff;
            lo_in   = {1'b0, lo_ff[DataWidth-1:1]};
            oper_in = {oper_ff[DataWidth-2:0], 1'b0};
         end else begin
            hi_in = ge ? sum[DataWidth-1:0] : add_a[DataWidth-1:0];
            lo_in = {lo_ff[DataWidth-2:0], ge};
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
         cmd_ff   <= ALU_MUL;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
         if (ctrl.start) begin
            cmd_ff <= ctrl.cmd;
         end
      end
   end

   // Working data
   always_ff @(posedge clock) begin
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      oper_ff <= oper_in;
   end

   assign done   = done_ff;
   assign res_hi = hi_ff;
   assign res_lo = lo_ff;

endmodule

@@ rtl/core/hex_keypad_calculator_core.sv @@
// ----------------------------------------------------------------------------
// hex_keypad_calculator_core: 32-bit hexadecimal keypad calculator
// Takes one key word, updates the entry and operator state, returns one
// display word.
// ----------------------------------------------------------------------------
// Each key word passes capture, decode and write-back before the display word
// is registered. A key that applies a pending multiply, divide or modulo
// (non-zero divisor) runs the shared iterative multiply/divide unit, one bit
// per cycle over 32 steps, between decode and write-back. The write-back
// waits while an earlier display word is still unread; req_ready is high
// only while the sequencer is idle.
module hex_keypad_calculator_core import hkc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OpWidth-1:0]   req_op,
   input  logic [KeyWidth-1:0]  req_key_code,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DataWidth-1:0] rsp_display_value,
   output logic                 rsp_display_updated,
   output logic                 rsp_beep
);

   state_type state_ff, state_in;

   logic [KeyWidth-1:0]  key_ff, key_in;
   logic                 nop_ff, nop_in;
   logic [DataWidth-1:0] entry_ff, entry_in;
   logic [DataWidth-1:0] saved_ff, saved_in;
   logic [KeyWidth-1:0]  pending_ff, pending_in;
   logic                 awaiting_ff, awaiting_in;
   logic                 rsp_valid_ff;
   logic [DataWidth-1:0] rsp_value_ff;
   logic                 rsp_updated_ff, rsp_beep_ff;
   logic                 updated_in, beep_in;

   logic                 accept, slot_free, commit;
   logic                 is_bs, is_esc, is_oper, need_alu, div_cmd;
   digit_type            digit;
   logic [DataWidth-1:0] base, op_result;
   alu_ctrl_type         alu_ctrl;
   logic                 alu_done;
   logic [DataWidth-1:0] alu_hi, alu_lo;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_WRITE) && slot_free;

   // Normalise the key at capture: left arrow, case, Enter
   always_comb begin
      key_in = (req_op == ReqOpLeft) ? KeyBackspace : req_key_code;
      if (req_op == ReqOpTyped || req_op == ReqOpLeft) begin
         if (key_in >= 8'h61 && key_in <= 8'h7a) begin
            key_in = key_in - KeyCaseShift;
         end
         if (key_in == KeyEnter) begin
            key_in = OpEquals;
         end
      end
      nop_in = (req_op == ReqOpNone);
   end

   // Classify the held key
   always_comb begin
      digit    = digit_decode(key_ff);
      is_bs    = !nop_ff && (key_ff == KeyBackspace);
      is_esc   = !nop_ff && (key_ff == KeyEscape);
      is_oper  = !nop_ff && !is_bs && !is_esc && !digit.valid && !awaiting_ff;
      div_cmd  = (pending_ff == OpDiv) || (pending_ff == OpMod);
      need_alu = is_oper && ((pending_ff == OpMul) || (div_cmd && entry_ff != '0));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = need_alu ? ST_WAIT : ST_WRITE;
         end
         ST_WAIT: begin
            if (alu_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      alu_ctrl.start = (state_ff == ST_DECODE) && need_alu;
      alu_ctrl.cmd   = div_cmd ? ALU_DIV : ALU_MUL;
   end

   // Apply the pending operator to the saved operand and the entry
   always_comb begin
      case (pending_ff)
         OpEquals: op_result = entry_ff;
         OpAdd:    op_result = saved_ff + entry_ff;
         OpSub:    op_result = saved_ff - entry_ff;
         OpMul:    op_result = alu_hi;
         OpAnd:    op_result = saved_ff & entry_ff;
         OpOr:     op_result = saved_ff | entry_ff;
         OpXor:    op_result = saved_ff ^ entry_ff;
         OpShl:    op_result = (entry_ff[DataWidth-1:StepWidth] != '0) ? '0 :
                               saved_ff << entry_ff[StepWidth-1:0];
         OpShr:    op_result = (entry_ff[DataWidth-1:StepWidth] != '0) ? '0 :
                               saved_ff >> entry_ff[StepWidth-1:0];
         OpDiv:    op_result = (entry_ff == '0) ? AllOnes : alu_lo;
         OpMod:    op_result = (entry_ff == '0) ? AllOnes : alu_hi;
         default:  op_result = '0;
      endcase
   end

   // Work out the new calculator state for the held key
   always_comb begin
      entry_in    = entry_ff;
      saved_in    = saved_ff;
      pending_in  = pending_ff;
      awaiting_in = awaiting_ff;
      updated_in  = 1'b0;
      beep_in     = 1'b0;
      base        = awaiting_ff ? '0 : entry_ff;
      if (nop_ff) begin
         updated_in = 1'b0;
      end else if (is_bs) begin
         entry_in   = {4'd0, entry_ff[DataWidth-1:4]};
         updated_in = 1'b1;
      end else if (is_esc) begin
         entry_in   = '0;
         updated_in = 1'b1;
      end else if (digit.valid) begin
         if (awaiting_ff) begin
            saved_in = entry_ff;
         end
         awaiting_in = 1'b0;
         if (base[DataWidth-1:DataWidth-4] == 4'd0) begin
            entry_in   = {base[DataWidth-5:0], digit.value};
            updated_in = 1'b1;
         end else begin
            entry_in = base;
            beep_in  = 1'b1;
         end
      end else if (is_oper) begin
         entry_in    = op_result;
         updated_in  = 1'b1;
         awaiting_in = 1'b1;
         pending_in  = key_ff;
      end
   end

   // Control and calculator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entry_ff     <= '0;
         saved_ff     <= '0;
         pending_ff   <= OpEquals;
         awaiting_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            entry_ff    <= entry_in;
            saved_ff    <= saved_in;
            pending_ff  <= pending_in;
            awaiting_ff <= awaiting_in;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the captured key and the display word
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= key_in;
         nop_ff <= nop_in;
      end
      if (commit) begin
         rsp_value_ff   <= entry_in;
         rsp_updated_ff <= updated_in;
         rsp_beep_ff    <= beep_in;
      end
   end

   hkc_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .opnd_a (saved_ff),
      .opnd_b (entry_ff),
      .done   (alu_done),
      .res_hi (alu_hi),
      .res_lo (alu_lo)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_display_value   = rsp_value_ff;
   assign rsp_display_updated = rsp_updated_ff;
   assign rsp_beep            = rsp_beep_ff;

endmodule

@@ tb/hex_keypad_calculator_core_tb.sv @@
// ----------------------------------------------------------------------------
// hex_keypad_calculator_core_tb: self-checking bench of the keypad calculator
// Sends key words through the request channel. A scoreboard keeps its own
// copy of the calculator state, predicts each display word and compares it
// with what comes back. Both channels idle at random. One stretch of the run
// has no idling at all.
// ----------------------------------------------------------------------------
module hex_keypad_calculator_core_tb import hkc_pkg::*; ();

   typedef struct {
      logic [DataWidth-1:0] value;
      logic                 updated;
      logic                 beep;
   } display_word_type;

   // Calculator shadow and the queue of display words still owed
   class display_board;
      logic [DataWidth-1:0] entry;
      logic [DataWidth-1:0] operand;
      logic [KeyWidth-1:0]  pending_op;
      bit                   awaiting;
      display_word_type     owed_q[$];
      int                   errors;
      int                   checked;
      int                   beeps;
      int                   applied;

      function new();
         entry      = '0;
         operand    = '0;
         pending_op = OpEquals;
         awaiting   = 1'b1;
         errors     = 0;
         checked    = 0;
         beeps      = 0;
         applied    = 0;
      endfunction

      function logic [DataWidth-1:0] compute(logic [KeyWidth-1:0] code,
                                             logic [DataWidth-1:0] a,
                                             logic [DataWidth-1:0] b);
         case (code)
            OpEquals: return b;
            OpAdd:    return a + b;
            OpSub:    return a - b;
            OpMul:    return a * b;
            OpAnd:    return a & b;
            OpOr:     return a | b;
            OpXor:    return a ^ b;
            OpShl:    return (b >= 32) ? '0 : a << b[4:0];
            OpShr:    return (b >= 32) ? '0 : a >> b[4:0];
            OpDiv:    return (b != 0) ? a / b : AllOnes;
            OpMod:    return (b != 0) ? a % b : AllOnes;
            default:  return '0;
         endcase
      endfunction

      // Advance the shadow by one accepted key word and queue its display word
      function void note_key(logic [OpWidth-1:0] op, logic [KeyWidth-1:0] key);
         logic [KeyWidth-1:0] k;
         display_word_type    w;
         int                  dv;
         k = key;
         w.updated = 1'b0;
         w.beep    = 1'b0;
         if (op == ReqOpLeft) k = KeyBackspace;
         // case folding and Enter only for typed and left-arrow keys
         if (op == ReqOpTyped || op == ReqOpLeft) begin
            if (k >= 8'h61 && k <= 8'h7a) k = k - KeyCaseShift;
            if (k == KeyEnter) k = OpEquals;
         end
         if (op != ReqOpNone) begin
            dv = -1;
            if (k >= 8'h30 && k <= 8'h39) dv = k - 8'h30;       // '0'..'9'
            else if (k >= 8'h41 && k <= 8'h46) dv = k - 8'h37;  // 'A'..'F'
            else if (k >= 8'h61 && k <= 8'h66) dv = k - 8'h57;  // 'a'..'f'
            if (k == KeyBackspace) begin
               entry = entry >> 4;
               w.updated = 1'b1;
            end else if (k == KeyEscape) begin
               entry = '0;
               w.updated = 1'b1;
            end else if (dv >= 0) begin
               if (awaiting) begin
                  operand = entry;
                  entry   = '0;
               end
               awaiting = 1'b0;
               if (entry <= (AllOnes >> 4)) begin
                  entry = (entry << 4) | DataWidth'(dv);
                  w.updated = 1'b1;
               end else begin
                  w.beep = 1'b1;
                  beeps++;
               end
            end else if (!awaiting) begin
               entry      = compute(pending_op, operand, entry);
               w.updated  = 1'b1;
               awaiting   = 1'b1;
               pending_op = k;
               applied++;
            end
         end
         w.value = entry;
         owed_q.push_back(w);
      endfunction

      // Compare a returned display word with the oldest one owed
      function void check_word(logic [DataWidth-1:0] value, logic updated,
                               logic beep);
         display_word_type w;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected display word value %h updated %b beep %b",
                     $time, value, updated, beep);
            errors++;
            return;
         end
         w = owed_q.pop_front();
         checked++;
         if (value !== w.value) begin
            $display("%0t: display_value expected %h actual %h", $time, w.value, value);
            errors++;
         end
         if (updated !== w.updated) begin
            $display("%0t: display_updated expected %b actual %b", $time, w.updated,
                     updated);
            errors++;
         end
         if (beep !== w.beep) begin
            $display("%0t: beep expected %b actual %b", $time, w.beep, beep);
            errors++;
         end
      endfunction

      function int outstanding();
         return owed_q.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [OpWidth-1:0]   req_op = ReqOpTyped;
   logic [KeyWidth-1:0]  req_key_code = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [DataWidth-1:0] rsp_display_value;
   logic                 rsp_display_updated;
   logic                 rsp_beep;

   display_board board = new();
   bit           calm = 1'b0;
   int           keys_sent = 0;

   hex_keypad_calculator_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_key_code        (req_key_code),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_display_value   (rsp_display_value),
      .rsp_display_updated (rsp_display_updated),
      .rsp_beep            (rsp_beep)
   );

   always #5 clock = ~clock;

   // Check each accepted display word, then pick the next ready level
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            board.check_word(rsp_display_value, rsp_display_updated, rsp_beep);
         rsp_ready <= calm || ($urandom_range(0, 99) >= 27);
      end
   end

   // Hold one key word on the request channel until it is taken
   task automatic send_key(input logic [OpWidth-1:0] op, input logic [KeyWidth-1:0] key);
      if (!calm) begin
         while ($urandom_range(0, 99) < 27) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_key_code <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_key(op, key);
      keys_sent++;
   endtask

   // Drop valid and hold off until every owed display word has come back or the guard expires
   task automatic drain(input int guard);
      int n;
      n = 0;
      req_valid <= 1'b0;
      while (board.outstanding() != 0 && n < guard) begin
         @(posedge clock);
         n++;
      end
   endtask

   task automatic send_digit(input logic [3:0] nib);
      logic [KeyWidth-1:0] k;
      if (nib < 10) k = 8'h30 + nib;
      else k = $urandom_range(0, 1) ? 8'h37 + nib : 8'h57 + nib;
      send_key($urandom_range(0, 1) ? ReqOpTyped : ReqOpButton, k);
   endtask

   // Type a value as hex digits, leading zeros dropped
   task automatic type_value(input logic [DataWidth-1:0] v);
      bit lead;
      lead = 1'b1;
      for (int i = 7; i >= 0; i--) begin
         if (v[i*4 +: 4] != 0 || i == 0) lead = 1'b0;
         if (!lead) send_digit(v[i*4 +: 4]);
      end
      // sometimes run past eight digits, or correct the entry
      case ($urandom_range(0, 11))
         0: send_digit(4'($urandom));
         1: send_key(ReqOpLeft, 8'($urandom));
         2: send_key(ReqOpTyped, KeyBackspace);
         3: begin
            send_key(ReqOpTyped, KeyEscape);
            send_digit(4'($urandom));
         end
         default: ;
      endcase
   endtask

   function automatic logic [KeyWidth-1:0] pick_operator();
      case ($urandom_range(0, 11))
         0:  return OpEquals;
         1:  return OpAdd;
         2:  return OpSub;
         3:  return OpMul;
         4:  return OpAnd;
         5:  return OpOr;
         6:  return OpXor;
         7:  return OpShl;
         8:  return OpShr;
         9:  return OpDiv;
         10: return OpMod;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [DataWidth-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0:       return '0;
         1, 2, 3: return $urandom_range(0, 40);
         4, 5:    return $urandom;
         6:       return AllOnes;
         default: return $urandom_range(0, 16'hffff);
      endcase
   endfunction

   initial begin
      logic [KeyWidth-1:0] code;
      bit                  squeezed;
      squeezed = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: unused op, case rules, overflow, backspace, escape,
      // division and modulo by zero, wide shift, unknown operator
      send_key(ReqOpNone, 8'hff);
      send_key(ReqOpTyped, 8'h66);              // typed 'f' folds to 'F'
      send_key(ReqOpButton, 8'h61);             // button 'a' stays lower case
      repeat (6) send_key(ReqOpTyped, 8'h39);
      send_key(ReqOpTyped, 8'h31);              // ninth digit: refused
      send_key(ReqOpLeft, 8'h5a);
      send_key(ReqOpTyped, KeyBackspace);
      send_key(ReqOpTyped, KeyEscape);
      send_key(ReqOpTyped, 8'h35);
      send_key(ReqOpTyped, OpDiv);
      send_key(ReqOpTyped, 8'h30);
      send_key(ReqOpTyped, OpMod);              // divide by zero
      send_key(ReqOpTyped, 8'h30);
      send_key(ReqOpTyped, KeyEnter);           // modulo by zero
      send_key(ReqOpButton, OpMod);             // no new entry: ignored
      send_key(ReqOpTyped, 8'h33);
      send_key(ReqOpTyped, OpShl);
      send_key(ReqOpTyped, 8'h32);
      send_key(ReqOpTyped, 8'h30);
      send_key(ReqOpButton, KeyEnter);          // shift by 32; Enter kept raw
      send_key(ReqOpTyped, 8'h31);
      send_key(ReqOpTyped, 8'h78);              // unknown operator applied
      drain(100000);

      // Random: mostly operand/operator sequences, some raw noise
      while (keys_sent < 1575) begin
         calm = (keys_sent >= 300 && keys_sent < 550);
         if (!squeezed && keys_sent >= 800) begin
            drain(100000);
            squeezed = 1'b1;
         end
         if ($urandom_range(0, 99) < 75) begin
            type_value(pick_operand());
            code = pick_operator();
            if (code == OpEquals && $urandom_range(0, 1))
               send_key(ReqOpTyped, KeyEnter);
            else
               send_key($urandom_range(0, 1) ? ReqOpTyped : ReqOpButton, code);
         end else begin
            send_key(2'($urandom_range(0, 3)), 8'($urandom));
         end
      end
      calm = 1'b0;

      // Wait for the last display words, then for stray ones
      drain(100000);
      repeat (60) @(posedge clock);
      if (board.outstanding() != 0) begin
         $display("%0t: %0d display words never arrived", $time, board.outstanding());
         board.errors++;
      end
      $display("Sent %0d key words; checked %0d display words, %0d operator results,",
               keys_sent, board.checked, board.applied);
      $display("%0d refused digits.", board.beeps);
      if (board.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/hkc_pkg.sv
rtl/core/hkc_alu.sv
rtl/core/hex_keypad_calculator_core.sv
tb/hex_keypad_calculator_core_tb.sv
